/* src/ptpd_pkg.sv */
package ptpd_pkg;

  // table geometry
  localparam int POINTS  = 11;
  localparam int TOP_IDX = POINTS - 1;
  localparam int IDX_W   = $clog2(POINTS);

  // field widths
  localparam int CLAR_W = 14;
  localparam int MV_W   = 15;
  localparam int ANG_W  = 8;
  localparam int DLY_W  = 15;
  localparam int CFG_W  = 14;
  localparam int CFG_IDX_W = 2;

  // fixed scaling
  localparam int FULL_SCALE = 10000;
  localparam int STEP       = FULL_SCALE / (POINTS - 1);
  localparam int OFF_ANGLE  = 180;

  // shared multiplier and divider
  localparam int OPD_W   = 14;
  localparam int NUM_W   = 22;
  localparam int DEN_W   = 15;
  localparam int DIV_CYCLES = NUM_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 2'd2;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 14'd10000;
  localparam logic [CFG_W-1:0] MIN_DELAY_RST   = 14'd500;
  localparam logic [CFG_W-1:0] MAX_DELAY_RST   = 14'd9500;

  typedef enum logic [1:0] {
    OP_VOLT,
    OP_ANGLE,
    OP_DELAY
  } op_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_DIV_V,
    ST_WAIT_V,
    ST_CHECK,
    ST_SEARCH,
    ST_DIV_A,
    ST_WAIT_A,
    ST_MUL_D,
    ST_DIV_D,
    ST_WAIT_D,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    range_step;
    logic    mul_en;
    logic    div_start;
    op_sel_t op;
    logic    take_mv;
    logic    ang_first;
    logic    ang_off;
    logic    seg_step;
    logic    take_ang;
    logic    take_delay;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic range_done;
    logic v_high;
    logic v_low;
    logic seg_hit;
    logic div_done;
  } status_t;

  // clarity to millivolt table
  function automatic logic [MV_W-1:0] clar_mv(input logic [IDX_W-1:0] i);
    logic [MV_W-1:0] r;
    case (i)
      4'd0:    r = 15'd0;
      4'd1:    r = 15'd2400;
      4'd2:    r = 15'd3100;
      4'd3:    r = 15'd3500;
      4'd4:    r = 15'd3900;
      4'd5:    r = 15'd4200;
      4'd6:    r = 15'd4600;
      4'd7:    r = 15'd5000;
      4'd8:    r = 15'd5400;
      4'd9:    r = 15'd6500;
      4'd10:   r = 15'd10000;
      default: r = '0;
    endcase
    return r;
  endfunction

  // falling voltage table of the angle lookup
  function automatic logic [MV_W-1:0] volt_mv(input logic [IDX_W-1:0] i);
    logic [MV_W-1:0] r;
    case (i)
      4'd0:    r = 15'd22800;
      4'd1:    r = 15'd20000;
      4'd2:    r = 15'd17000;
      4'd3:    r = 15'd11300;
      4'd4:    r = 15'd7680;
      4'd5:    r = 15'd5500;
      4'd6:    r = 15'd3500;
      4'd7:    r = 15'd2700;
      4'd8:    r = 15'd1900;
      4'd9:    r = 15'd1250;
      4'd10:   r = 15'd1000;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [ANG_W-1:0] angle_deg(input logic [IDX_W-1:0] i);
    logic [ANG_W-1:0] r;
    case (i)
      4'd0:    r = 8'd5;
      4'd1:    r = 8'd45;
      4'd2:    r = 8'd90;
      4'd3:    r = 8'd120;
      4'd4:    r = 8'd135;
      4'd5:    r = 8'd145;
      4'd6:    r = 8'd155;
      4'd7:    r = 8'd160;
      4'd8:    r = 8'd165;
      4'd9:    r = 8'd170;
      4'd10:   r = 8'd175;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* src/ptpd_div.sv */
module ptpd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptpd_pkg::NUM_W-1:0]    dividend,
  input  logic [ptpd_pkg::DEN_W-1:0]    divisor,
  output logic                          done,
  output logic [ptpd_pkg::NUM_W-1:0]    quotient
);

  localparam logic [ptpd_pkg::DIV_CNT_W-1:0] LAST =
    ptpd_pkg::DIV_CNT_W'(ptpd_pkg::DIV_CYCLES - 1);

  logic                             busy;
  logic [ptpd_pkg::DIV_CNT_W-1:0]   cnt;
  logic [ptpd_pkg::DEN_W-1:0]       rem;
  logic [ptpd_pkg::NUM_W-1:0]       quo;

  logic [ptpd_pkg::DEN_W:0]         t1, t2, dext;
  logic                             ge1, ge2;
  logic [ptpd_pkg::DEN_W-1:0]       r1, rem_next;
  logic [ptpd_pkg::NUM_W-1:0]       q1, quo_next;

  // two restoring steps a cycle
  always_comb begin
    dext = {1'b0, divisor};
    t1   = {rem, quo[ptpd_pkg::NUM_W-1]};
    ge1  = (t1 >= dext);
    r1   = ge1 ? ptpd_pkg::DEN_W'(t1 - dext) : t1[ptpd_pkg::DEN_W-1:0];
    q1   = {quo[ptpd_pkg::NUM_W-2:0], ge1};
    t2   = {r1, q1[ptpd_pkg::NUM_W-1]};
    ge2  = (t2 >= dext);
    rem_next = ge2 ? ptpd_pkg::DEN_W'(t2 - dext) : t2[ptpd_pkg::DEN_W-1:0];
    quo_next = {q1[ptpd_pkg::NUM_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

/* src/ptpd_datapath.sv */
module ptpd_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptpd_pkg::CFG_W-1:0]        cfg_data,
  input  logic [ptpd_pkg::CLAR_W-1:0]       clarity_centi_pct,
  input  ptpd_pkg::cmd_t                    cmd,
  output ptpd_pkg::status_t                 status,
  output logic [ptpd_pkg::MV_W-1:0]         target_voltage_mv,
  output logic [ptpd_pkg::ANG_W-1:0]        firing_angle_deg,
  output logic [ptpd_pkg::DLY_W-1:0]        firing_delay_us,
  output logic                              never_fire
);

  localparam logic [ptpd_pkg::IDX_W-1:0] TOP =
    ptpd_pkg::IDX_W'(ptpd_pkg::TOP_IDX);
  localparam logic [ptpd_pkg::CLAR_W-1:0] FULL =
    ptpd_pkg::CLAR_W'(ptpd_pkg::FULL_SCALE);
  localparam logic [ptpd_pkg::CLAR_W-1:0] STEP_C =
    ptpd_pkg::CLAR_W'(ptpd_pkg::STEP);
  localparam logic [ptpd_pkg::ANG_W-1:0] OFF =
    ptpd_pkg::ANG_W'(ptpd_pkg::OFF_ANGLE);

  // configuration
  logic [ptpd_pkg::CFG_W-1:0] half_period, min_delay, max_delay;

  // working registers
  logic [ptpd_pkg::CLAR_W-1:0] c_rem;
  logic [ptpd_pkg::IDX_W-1:0]  idx, seg;
  logic [ptpd_pkg::MV_W-1:0]   mv;
  logic [ptpd_pkg::ANG_W-1:0]  ang;
  logic [ptpd_pkg::DLY_W-1:0]  delay;
  logic                        off;
  logic [ptpd_pkg::NUM_W-1:0]  prod;

  logic [ptpd_pkg::IDX_W-1:0]    idx_up, seg_up;
  logic [ptpd_pkg::MV_W-1:0]     mv_delta, v_diff, span;
  logic [ptpd_pkg::ANG_W-1:0]    a_delta;
  logic [ptpd_pkg::OPD_W-1:0]    opa, opb;
  logic [2*ptpd_pkg::OPD_W-1:0]  mul_full;
  logic [ptpd_pkg::DEN_W-1:0]    divisor;
  logic                          div_done;
  logic [ptpd_pkg::NUM_W-1:0]    quotient;
  logic [ptpd_pkg::DLY_W-1:0]    d_raw, d_lo, d_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= ptpd_pkg::HALF_PERIOD_RST;
      min_delay   <= ptpd_pkg::MIN_DELAY_RST;
      max_delay   <= ptpd_pkg::MAX_DELAY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ptpd_pkg::CFG_HALF_PERIOD: half_period <= cfg_data;
        ptpd_pkg::CFG_MIN_DELAY:   min_delay   <= cfg_data;
        ptpd_pkg::CFG_MAX_DELAY:   max_delay   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    idx_up   = idx + 1'b1;
    seg_up   = seg + 1'b1;
    // top index has no segment above it
    mv_delta = (idx < TOP) ? ptpd_pkg::clar_mv(idx_up) - ptpd_pkg::clar_mv(idx) : '0;
    v_diff   = ptpd_pkg::volt_mv(seg) - mv;
    span     = ptpd_pkg::volt_mv(seg) - ptpd_pkg::volt_mv(seg_up);
    a_delta  = ptpd_pkg::angle_deg(seg_up) - ptpd_pkg::angle_deg(seg);
    case (cmd.op)
      ptpd_pkg::OP_VOLT: begin
        opa     = c_rem;
        opb     = mv_delta[ptpd_pkg::OPD_W-1:0];
        divisor = ptpd_pkg::DEN_W'(STEP_C);
      end
      ptpd_pkg::OP_ANGLE: begin
        opa     = v_diff[ptpd_pkg::OPD_W-1:0];
        opb     = ptpd_pkg::OPD_W'(a_delta);
        divisor = span;
      end
      ptpd_pkg::OP_DELAY: begin
        opa     = ptpd_pkg::OPD_W'(ang);
        opb     = half_period;
        divisor = ptpd_pkg::DEN_W'(OFF);
      end
      default: begin
        opa     = '0;
        opb     = '0;
        divisor = '0;
      end
    endcase
    mul_full = opa * opb;
  end

  ptpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // delay clamps, upper one wins
  always_comb begin
    d_raw     = quotient[ptpd_pkg::DLY_W-1:0];
    d_lo      = (d_raw < ptpd_pkg::DLY_W'(min_delay)) ? ptpd_pkg::DLY_W'(min_delay) : d_raw;
    d_clamped = (d_lo > ptpd_pkg::DLY_W'(max_delay)) ? ptpd_pkg::DLY_W'(max_delay) : d_lo;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_rem <= (clarity_centi_pct > FULL) ? FULL : clarity_centi_pct;
      idx   <= '0;
      seg   <= '0;
    end
    if (cmd.range_step) begin
      c_rem <= c_rem - STEP_C;
      idx   <= idx_up;
    end
    if (cmd.mul_en) begin
      prod <= mul_full[ptpd_pkg::NUM_W-1:0];
    end
    if (cmd.take_mv) begin
      mv <= ptpd_pkg::clar_mv(idx) + quotient[ptpd_pkg::MV_W-1:0];
    end
    if (cmd.seg_step) begin
      seg <= seg_up;
    end
    if (cmd.ang_first) begin
      ang <= ptpd_pkg::angle_deg('0);
    end
    if (cmd.ang_off) begin
      ang <= OFF;
    end
    if (cmd.take_ang) begin
      ang <= ptpd_pkg::angle_deg(seg) + quotient[ptpd_pkg::ANG_W-1:0];
    end
    if (cmd.take_delay) begin
      if (ang >= OFF) begin
        delay <= ptpd_pkg::DLY_W'(half_period) + 1'b1;
        off   <= 1'b1;
      end else begin
        delay <= d_clamped;
        off   <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      target_voltage_mv <= mv;
      firing_angle_deg  <= ang;
      firing_delay_us   <= delay;
      never_fire        <= off;
    end
  end

  always_comb begin
    status.range_done = (c_rem < STEP_C) || (idx == TOP);
    status.v_high     = (mv >= ptpd_pkg::volt_mv('0));
    status.v_low      = (mv <= ptpd_pkg::volt_mv(TOP));
    status.seg_hit    = (mv >= ptpd_pkg::volt_mv(seg_up));
    status.div_done   = div_done;
  end

  a_never_fire_angle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (never_fire == (firing_angle_deg == OFF)))
    else $error("never_fire disagrees with the firing angle");

  a_range_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.range_step |-> (idx < TOP))
    else $error("clarity segment index ran past the table");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_step |-> (seg_up < TOP))
    else $error("voltage search ran past the last segment");

endmodule

/* src/ptpd_ctrl.sv */
module ptpd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  ptpd_pkg::status_t  status,
  output ptpd_pkg::cmd_t     cmd
);

  ptpd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptpd_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.op     = ptpd_pkg::OP_VOLT;
    in_ready   = 1'b0;
    case (state)
      ptpd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ptpd_pkg::ST_RANGE;
        end
      end
      ptpd_pkg::ST_RANGE: begin
        if (status.range_done) begin
          cmd.mul_en = 1'b1;
          state_next = ptpd_pkg::ST_DIV_V;
        end else begin
          cmd.range_step = 1'b1;
        end
      end
      ptpd_pkg::ST_DIV_V: begin
        cmd.div_start = 1'b1;
        state_next    = ptpd_pkg::ST_WAIT_V;
      end
      ptpd_pkg::ST_WAIT_V: begin
        if (status.div_done) begin
          cmd.take_mv = 1'b1;
          state_next  = ptpd_pkg::ST_CHECK;
        end
      end
      ptpd_pkg::ST_CHECK: begin
        if (status.v_high) begin
          cmd.ang_first = 1'b1;
          state_next    = ptpd_pkg::ST_MUL_D;
        end else if (status.v_low) begin
          cmd.ang_off = 1'b1;
          state_next  = ptpd_pkg::ST_MUL_D;
        end else begin
          state_next = ptpd_pkg::ST_SEARCH;
        end
      end
      ptpd_pkg::ST_SEARCH: begin
        cmd.op = ptpd_pkg::OP_ANGLE;
        if (status.seg_hit) begin
          cmd.mul_en = 1'b1;
          state_next = ptpd_pkg::ST_DIV_A;
        end else begin
          cmd.seg_step = 1'b1;
        end
      end
      ptpd_pkg::ST_DIV_A: begin
        cmd.op        = ptpd_pkg::OP_ANGLE;
        cmd.div_start = 1'b1;
        state_next    = ptpd_pkg::ST_WAIT_A;
      end
      ptpd_pkg::ST_WAIT_A: begin
        cmd.op = ptpd_pkg::OP_ANGLE;
        if (status.div_done) begin
          cmd.take_ang = 1'b1;
          state_next   = ptpd_pkg::ST_MUL_D;
        end
      end
      ptpd_pkg::ST_MUL_D: begin
        cmd.op     = ptpd_pkg::OP_DELAY;
        cmd.mul_en = 1'b1;
        state_next = ptpd_pkg::ST_DIV_D;
      end
      ptpd_pkg::ST_DIV_D: begin
        cmd.op        = ptpd_pkg::OP_DELAY;
        cmd.div_start = 1'b1;
        state_next    = ptpd_pkg::ST_WAIT_D;
      end
      ptpd_pkg::ST_WAIT_D: begin
        cmd.op = ptpd_pkg::OP_DELAY;
        if (status.div_done) begin
          cmd.take_delay = 1'b1;
          state_next     = ptpd_pkg::ST_OUT;
        end
      end
      ptpd_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ptpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ptpd_pkg::ST_IDLE;
      end
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == ptpd_pkg::ST_WAIT_V || state == ptpd_pkg::ST_WAIT_A ||
                         state == ptpd_pkg::ST_WAIT_D))
    else $error("divider finished outside a wait state");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while one is in flight");

  a_out_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

/* src/percent_to_phase_delay.sv */
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------------
// cfg      | in        | cfg_wr_en              | cfg_index, cfg_data
// in       | in        | in_valid / in_ready    | clarity_centi_pct
// out      | out       | out_valid / out_ready  | target_voltage_mv, firing_angle_deg,
//          |           |                        | firing_delay_us, never_fire
//
// one word at a time; the time from acceptance to result is set by two or three passes of
// the shared 2-bit-a-cycle divider, the clarity segment walk and the voltage segment search
// rst is synchronous and restores the three delay settings to their defaults
// in_ready rises again once the result sits in the output register, so a new word
// is taken while the previous result waits on out_ready
// a stalled result holds the block in its last state until the output register frees
module percent_to_phase_delay (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_wr_en,
  input  logic [ptpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ptpd_pkg::CFG_W-1:0]        cfg_data,
  // clarity command
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptpd_pkg::CLAR_W-1:0]       clarity_centi_pct,
  // firing result
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptpd_pkg::MV_W-1:0]         target_voltage_mv,
  output logic [ptpd_pkg::ANG_W-1:0]        firing_angle_deg,
  output logic [ptpd_pkg::DLY_W-1:0]        firing_delay_us,
  output logic                              never_fire
);

  // sequencing commands and datapath flags
  ptpd_pkg::cmd_t    cmd;
  ptpd_pkg::status_t status;

  // controller walks the stages: clarity segment, voltage interpolation,
  // angle search and interpolation, delay scaling, result hand-off
  ptpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: settings, shared multiplier, shared divider, tables, result register
  ptpd_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .clarity_centi_pct (clarity_centi_pct),
    .cmd               (cmd),
    .status            (status),
    .target_voltage_mv (target_voltage_mv),
    .firing_angle_deg  (firing_angle_deg),
    .firing_delay_us   (firing_delay_us),
    .never_fire        (never_fire)
  );

endmodule
